// ----- hdl/imaxpq_pkg.sv -----
// Shared widths, opcodes and heap entry type for the indexed max priority queue.
package imaxpq_pkg;

  localparam int NODE_W         = 7;
  localparam int WGT_W          = 32;
  localparam int CNT_W          = 8;
  localparam int NODE_COUNT_DEF = 128;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0]       node;
    logic signed [WGT_W-1:0] wgt;
  } heap_ent_t;

endpackage

// ----- hdl/imaxpq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
module imaxpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/imaxpq_cmp.sv -----
// Shared signed weight comparator with winner select, used by every sift step.
module imaxpq_cmp (
  input  imaxpq_pkg::heap_ent_t a_ent,
  input  imaxpq_pkg::heap_ent_t b_ent,
  output logic                  a_gt,
  output imaxpq_pkg::heap_ent_t win_ent
);
  import imaxpq_pkg::*;

  // strict: ties keep b
  assign a_gt    = $signed(a_ent.wgt) > $signed(b_ent.wgt);
  assign win_ent = a_gt ? a_ent : b_ent;

endmodule

// ----- hdl/indexed_max_priority_queue_core.sv -----
// Top level of the indexed max priority queue: sequencer, heap and position memories.
//
// Usage
//   Input channel (in_valid/in_ready) carries one transaction per operation:
//   in_opcode push-or-raise or pop, in_node_id, in_new_weight. The result
//   channel (out_valid/out_ready) returns exactly one transaction per input:
//   the node popped or pushed, its weight, the entry count afterwards and an
//   error flag (pop on empty, push when full or node id out of range).
//   Timing is set by the single read port of the heap RAM and the one shared
//   comparator, one read per compared entry; the next transaction is taken in
//   the cycle after the result is loaded.
//   One operation is in flight at a time; in_ready is high only when the
//   sequencer is idle. A finished result sits in the output register, so a
//   new transaction can be taken while the receiver stalls; the sequencer
//   then holds its next result until the output register frees up.
//   Reset: the heap is emptied and a clearing pass zeroes every entry of the
//   position map, with in_ready low throughout.
module indexed_max_priority_queue_core #(
  parameter int NODE_COUNT = imaxpq_pkg::NODE_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_opcode,
  input  logic [imaxpq_pkg::NODE_W-1:0]         in_node_id,
  input  logic signed [imaxpq_pkg::WGT_W-1:0]   in_new_weight,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [imaxpq_pkg::NODE_W-1:0]         out_result_node,
  output logic signed [imaxpq_pkg::WGT_W-1:0]   out_result_weight,
  output logic [imaxpq_pkg::CNT_W-1:0]          out_entry_count,
  output logic                                  out_error_flag
);
  import imaxpq_pkg::*;

  // heap slots are 1..NODE_COUNT, slot 0 unused; position 0 means absent
  localparam int SLOT_W     = $clog2(NODE_COUNT + 1);
  localparam int NODE_IDX_W = $clog2(NODE_COUNT);
  localparam int ENT_W      = $bits(heap_ent_t);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PU_POS  = 4'd2;
  localparam logic [3:0] S_PO_TOP  = 4'd3;
  localparam logic [3:0] S_PO_LAST = 4'd4;
  localparam logic [3:0] S_SU_CHK  = 4'd5;
  localparam logic [3:0] S_SU_CMP  = 4'd6;
  localparam logic [3:0] S_SD_CHK  = 4'd7;
  localparam logic [3:0] S_SD_L    = 4'd8;
  localparam logic [3:0] S_SD_R    = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  // control state
  logic [3:0]            state_r, state_nxt;
  logic [SLOT_W-1:0]     count_r, count_nxt;
  logic [NODE_IDX_W-1:0] clr_addr_r, clr_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // working payload
  heap_ent_t             cur_r, cur_nxt;       // entry being sifted (the "hole" value)
  logic [SLOT_W-1:0]     p_r, p_nxt;           // slot of the hole
  heap_ent_t             best_r, best_nxt;     // best of parent/left during sift-down
  logic [SLOT_W-1:0]     best_slot_r, best_slot_nxt;
  logic                  best_child_r, best_child_nxt;
  logic [NODE_W-1:0]     res_node_r, res_node_nxt;
  logic signed [WGT_W-1:0] res_wgt_r, res_wgt_nxt;
  logic                  err_r, err_nxt;

  // output register
  logic [NODE_W-1:0]       out_node_r, out_node_nxt;
  logic signed [WGT_W-1:0] out_wgt_r, out_wgt_nxt;
  logic [CNT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic                    out_err_r, out_err_nxt;

  // memory ports
  logic                  heap_we;
  logic [SLOT_W-1:0]     heap_waddr, heap_raddr;
  heap_ent_t             heap_wdata, heap_rdata;
  logic                  pos_we;
  logic [NODE_IDX_W-1:0] pos_waddr, pos_raddr;
  logic [SLOT_W-1:0]     pos_wdata, pos_rdata;

  // shared comparator
  heap_ent_t cmp_a, cmp_b, cmp_win;
  logic      cmp_gt;

  logic [SLOT_W:0] lc, rc, cnt_ext;
  logic            node_oob;

  assign lc       = {p_r, 1'b0};
  assign rc       = {p_r, 1'b1};
  assign cnt_ext  = {1'b0, count_r};
  assign node_oob = 32'(in_node_id) >= 32'(NODE_COUNT);

  assign pos_raddr = NODE_IDX_W'(in_node_id);

  assign cmp_a = (state_r == S_SU_CMP) ? cur_r : heap_rdata;
  assign cmp_b = (state_r == S_SU_CMP) ? heap_rdata :
                 ((state_r == S_SD_R) ? best_r : cur_r);

  imaxpq_cmp u_cmp (
    .a_ent   (cmp_a),
    .b_ent   (cmp_b),
    .a_gt    (cmp_gt),
    .win_ent (cmp_win)
  );

  imaxpq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODE_COUNT + 1)
  ) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  imaxpq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NODE_COUNT)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    clr_addr_nxt   = clr_addr_r;
    cur_nxt        = cur_r;
    p_nxt          = p_r;
    best_nxt       = best_r;
    best_slot_nxt  = best_slot_r;
    best_child_nxt = best_child_r;
    res_node_nxt   = res_node_r;
    res_wgt_nxt    = res_wgt_r;
    err_nxt        = err_r;

    out_valid_nxt  = out_valid_r & ~out_ready;
    out_node_nxt   = out_node_r;
    out_wgt_nxt    = out_wgt_r;
    out_cnt_nxt    = out_cnt_r;
    out_err_nxt    = out_err_r;

    heap_we    = 1'b0;
    heap_waddr = p_r;
    heap_wdata = cur_r;
    heap_raddr = SLOT_W'(1);
    pos_we     = 1'b0;
    pos_waddr  = NODE_IDX_W'(cur_r.node);
    pos_wdata  = p_r;

    unique case (state_r)
      S_CLR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_addr_r;
        pos_wdata = '0;
        if (clr_addr_r == NODE_IDX_W'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cur_nxt.node = in_node_id;
          cur_nxt.wgt  = in_new_weight;
          res_node_nxt = in_node_id;
          res_wgt_nxt  = in_new_weight;
          err_nxt      = 1'b0;
          if (in_opcode == OP_POP) begin
            res_node_nxt = '0;
            res_wgt_nxt  = '0;
            if (count_r == '0) begin
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              heap_raddr = SLOT_W'(1);
              state_nxt  = S_PO_TOP;
            end
          end else if (node_oob) begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_PU_POS;
          end
        end
      end

      S_PU_POS: begin
        if (pos_rdata != '0) begin
          // raise: overwrite in place, climb from current slot
          p_nxt     = pos_rdata;
          state_nxt = S_SU_CHK;
        end else if (count_r == SLOT_W'(NODE_COUNT)) begin
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          count_nxt = count_r + 1'b1;
          p_nxt     = count_r + 1'b1;
          state_nxt = S_SU_CHK;
        end
      end

      S_SU_CHK: begin
        if (p_r == SLOT_W'(1)) begin
          heap_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          heap_raddr = p_r >> 1;
          state_nxt  = S_SU_CMP;
        end
      end

      S_SU_CMP: begin
        if (cmp_gt) begin
          // parent drops into the hole
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = NODE_IDX_W'(heap_rdata.node);
          p_nxt      = p_r >> 1;
          state_nxt  = S_SU_CHK;
        end else begin
          heap_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_PO_TOP: begin
        res_node_nxt = heap_rdata.node;
        res_wgt_nxt  = heap_rdata.wgt;
        pos_we       = 1'b1;
        pos_waddr    = NODE_IDX_W'(heap_rdata.node);
        pos_wdata    = '0;
        if (count_r == SLOT_W'(1)) begin
          count_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          heap_raddr = count_r;
          state_nxt  = S_PO_LAST;
        end
      end

      S_PO_LAST: begin
        cur_nxt   = heap_rdata;
        count_nxt = count_r - 1'b1;
        p_nxt     = SLOT_W'(1);
        state_nxt = S_SD_CHK;
      end

      S_SD_CHK: begin
        if (lc > cnt_ext) begin
          heap_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          heap_raddr = lc[SLOT_W-1:0];
          state_nxt  = S_SD_L;
        end
      end

      S_SD_L: begin
        if (rc <= cnt_ext) begin
          best_nxt       = cmp_win;
          best_slot_nxt  = cmp_gt ? lc[SLOT_W-1:0] : p_r;
          best_child_nxt = cmp_gt;
          heap_raddr     = rc[SLOT_W-1:0];
          state_nxt      = S_SD_R;
        end else if (cmp_gt) begin
          // left child alone and larger: it moves up
          heap_we    = 1'b1;
          heap_wdata = cmp_win;
          pos_we     = 1'b1;
          pos_waddr  = NODE_IDX_W'(cmp_win.node);
          p_nxt      = lc[SLOT_W-1:0];
          state_nxt  = S_SD_CHK;
        end else begin
          heap_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_SD_R: begin
        if (cmp_gt || best_child_r) begin
          heap_we    = 1'b1;
          heap_wdata = cmp_win;
          pos_we     = 1'b1;
          pos_waddr  = NODE_IDX_W'(cmp_win.node);
          p_nxt      = cmp_gt ? rc[SLOT_W-1:0] : best_slot_r;
          state_nxt  = S_SD_CHK;
        end else begin
          heap_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = res_node_r;
          out_wgt_nxt   = res_wgt_r;
          out_cnt_nxt   = CNT_W'(count_r);
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      count_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    p_r          <= p_nxt;
    best_r       <= best_nxt;
    best_slot_r  <= best_slot_nxt;
    best_child_r <= best_child_nxt;
    res_node_r   <= res_node_nxt;
    res_wgt_r    <= res_wgt_nxt;
    err_r        <= err_nxt;
    out_node_r   <= out_node_nxt;
    out_wgt_r    <= out_wgt_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_node   = out_node_r;
  assign out_result_weight = out_wgt_r;
  assign out_entry_count   = out_cnt_r;
  assign out_error_flag    = out_err_r;

endmodule

// ----- hdl/imaxpq_chk.sv -----
// Port-level checker for the indexed max priority queue, bound to the top level.
module imaxpq_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [imaxpq_pkg::NODE_W-1:0]       out_result_node,
  input logic signed [imaxpq_pkg::WGT_W-1:0] out_result_weight,
  input logic [imaxpq_pkg::CNT_W-1:0]        out_entry_count,
  input logic                                out_error_flag
);
  import imaxpq_pkg::*;

  logic [1:0]       pend_r, pend_nxt;      // transactions taken but not yet returned
  logic [CNT_W-1:0] last_cnt_r, last_cnt_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  always_comb begin
    pend_nxt     = pend_r + 2'(in_acc) - 2'(out_acc);
    last_cnt_nxt = out_acc ? out_entry_count : last_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      last_cnt_r <= '0;
    end else begin
      pend_r     <= pend_nxt;
      last_cnt_r <= last_cnt_nxt;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_node)
      && $stable(out_result_weight) && $stable(out_entry_count) && $stable(out_error_flag))
    else $error("result changed while stalled");

  // position map clear runs after reset
  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input accepted straight after reset");

  // every result belongs to an earlier transaction, at most two outstanding
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0 && pend_r != 2'd3)
    else $error("result without matching input");

  // count moves by at most one per transaction, and not at all on error
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count == last_cnt_r
      || (!out_error_flag && out_entry_count == CNT_W'(last_cnt_r + 1'b1))
      || (!out_error_flag && out_entry_count == CNT_W'(last_cnt_r - 1'b1)))
    else $error("entry count stepped wrongly");

endmodule

bind indexed_max_priority_queue_core imaxpq_chk u_imaxpq_chk (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the indexed max priority queue core.
`timescale 1ns / 1ps

module testbench;
  import imaxpq_pkg::*;

  // Run shape
  localparam int HEAP_DEPTH   = NODE_COUNT_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 400000;  // clear pass + ~1750 items at worst pacing, many times over
  localparam int TAIL_CYCLES  = 3 * 7 + 5 + 20;  // deepest pop plus margin
  localparam int LONG_HOLD    = 400;  // receiver back-pressure stretch
  localparam int HOLD_AFTER   = 300;  // results seen before the long hold starts

  localparam logic signed [WGT_W-1:0] WGT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WGT_W-1:0] WGT_MIN = 32'sh8000_0000;

  typedef enum int { W_FULL, W_TIE, W_EDGE, W_NEAR } wstyle_t;
  typedef enum int { PICK_ANY, PICK_ABSENT, PICK_PRESENT } pick_t;
  typedef enum int { SEG_FILL, SEG_MIXED, SEG_DRAIN, SEG_TIES } seg_kind_t;
  typedef enum int { RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC } rx_mode_t;

  // One result transaction as seen on the out_ channel
  typedef struct packed {
    logic [NODE_W-1:0]       node;
    logic signed [WGT_W-1:0] wgt;
    logic [CNT_W-1:0]        cnt;
    logic                    err;
  } qresult_t;

  // Directed table row: fixed_res set means the result is typed in by hand
  typedef struct {
    logic                    op;
    logic [NODE_W-1:0]       node;
    logic signed [WGT_W-1:0] wgt;
    bit                      fixed_res;
    qresult_t                res;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_opcode;
  logic [NODE_W-1:0]       in_node_id;
  logic signed [WGT_W-1:0] in_new_weight;
  logic                    out_valid;
  logic                    out_ready;
  logic [NODE_W-1:0]       out_result_node;
  logic signed [WGT_W-1:0] out_result_weight;
  logic [CNT_W-1:0]        out_entry_count;
  logic                    out_error_flag;

  indexed_max_priority_queue_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_node_id        (in_node_id),
    .in_new_weight     (in_new_weight),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_node   (out_result_node),
    .out_result_weight (out_result_weight),
    .out_entry_count   (out_entry_count),
    .out_error_flag    (out_error_flag)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Heap predictor: slots 1..heap_cnt hold live entries, slot_of gives the slot
  // of each node (0 = absent). Kept in step with every accepted input.
  // ---------------------------------------------------------------------------
  logic [NODE_W-1:0]       heap_nd [1:HEAP_DEPTH];
  logic signed [WGT_W-1:0] heap_wt [1:HEAP_DEPTH];
  logic [CNT_W-1:0]        slot_of [0:HEAP_DEPTH-1];
  int                      heap_cnt;

  qresult_t  pending_res[$];   // results owed by the block, oldest first
  stim_row_t dir_rows[$];
  qresult_t  got_front;
  int        fail_cnt = 0;
  int        got_cnt = 0;
  int        sent_rand;
  int        burst_left;
  int        cyc_cnt = 0;

  function automatic void swap_slots(int p, int q);
    logic [NODE_W-1:0]       tn;
    logic signed [WGT_W-1:0] tw;
    tn = heap_nd[p];
    tw = heap_wt[p];
    heap_nd[p] = heap_nd[q];
    heap_wt[p] = heap_wt[q];
    heap_nd[q] = tn;
    heap_wt[q] = tw;
    slot_of[heap_nd[p]] = CNT_W'(p);
    slot_of[heap_nd[q]] = CNT_W'(q);
  endfunction

  // climb only while strictly heavier than the parent
  function automatic void sift_up(int p);
    while (p > 1 && heap_wt[p] > heap_wt[p / 2]) begin
      swap_slots(p, p / 2);
      p = p / 2;
    end
  endfunction

  // left child wins on strictly greater, right child must beat the pick so far
  function automatic void sift_down(int p);
    int best;
    bit done;
    done = 1'b0;
    while (!done && p * 2 <= heap_cnt) begin
      best = p;
      if (heap_wt[p * 2] > heap_wt[best]) best = p * 2;
      if (p * 2 + 1 <= heap_cnt && heap_wt[p * 2 + 1] > heap_wt[best]) best = p * 2 + 1;
      if (best == p) begin
        done = 1'b1;
      end else begin
        swap_slots(p, best);
        p = best;
      end
    end
  endfunction

  function automatic qresult_t heap_apply(logic op, logic [NODE_W-1:0] node,
                                          logic signed [WGT_W-1:0] w);
    qresult_t r;
    int       p;
    r = '0;
    if (op == OP_POP) begin
      if (heap_cnt == 0) begin
        r.err = 1'b1;
      end else begin
        r.node = heap_nd[1];
        r.wgt  = heap_wt[1];
        if (heap_cnt > 1) swap_slots(1, heap_cnt);
        slot_of[r.node] = '0;
        heap_cnt--;
        sift_down(1);
      end
    end else begin
      r.node = node;
      r.wgt  = w;
      if (slot_of[node] != 0) begin
        // raise: overwrite in place, sift up only (a lower weight stays put)
        p = slot_of[node];
        heap_wt[p] = w;
        sift_up(p);
      end else if (heap_cnt >= HEAP_DEPTH) begin
        r.err = 1'b1;
      end else begin
        heap_cnt++;
        heap_nd[heap_cnt] = node;
        heap_wt[heap_cnt] = w;
        slot_of[node] = CNT_W'(heap_cnt);
        sift_up(heap_cnt);
      end
    end
    r.cnt = CNT_W'(heap_cnt);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [NODE_W-1:0] pick_node(pick_t how);
    int                start;
    int                idx;
    bit                found;
    logic [NODE_W-1:0] n;
    start = $urandom_range(0, HEAP_DEPTH - 1);
    n     = NODE_W'(start);
    found = (how == PICK_ANY);
    for (int k = 0; k < HEAP_DEPTH; k++) begin
      idx = (start + k) % HEAP_DEPTH;
      if (!found && ((slot_of[idx] == 0) == (how == PICK_ABSENT))) begin
        n     = NODE_W'(idx);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic signed [WGT_W-1:0] pick_wgt(wstyle_t ws);
    int r;
    r = $urandom_range(0, 3);
    case (ws)
      W_TIE:  return $signed($urandom_range(0, 8)) - 4;  // narrow band, many ties
      W_EDGE: begin
        case (r)
          0:       return WGT_MAX;
          1:       return WGT_MIN;
          2:       return '0;
          default: return -1;
        endcase
      end
      W_NEAR: return $urandom_range(0, 1) ? WGT_MAX - r : WGT_MIN + r;
      default: return $urandom;
    endcase
  endfunction

  function automatic wstyle_t rand_style();
    return ($urandom_range(0, 9) < 6) ? W_FULL : wstyle_t'($urandom_range(1, 3));
  endfunction

  // valid low with junk on the payload
  task automatic rest(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_opcode     <= 1'($urandom);
      in_node_id    <= NODE_W'($urandom);
      in_new_weight <= $urandom;
    end
  endtask

  // bursts of back-to-back transactions, with an occasional long run
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 12));
    end
  endtask

  // hold one transaction until accepted, then book its expected result
  task automatic offer(logic op, logic [NODE_W-1:0] node, logic signed [WGT_W-1:0] w,
                       bit use_fixed, qresult_t fixed);
    qresult_t r;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_node_id    <= node;
    in_new_weight <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    r = heap_apply(op, node, w);
    pending_res.push_back(use_fixed ? fixed : r);
    pace();
  endtask

  task automatic issue(logic op, pick_t how, wstyle_t ws);
    logic [NODE_W-1:0]       n;
    logic signed [WGT_W-1:0] w;
    n = pick_node(how);
    w = pick_wgt(ws);
    offer(op, n, w, 1'b0, '0);
    sent_rand++;
  endtask

  // sender stops until every booked result has come back
  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(logic op, logic [NODE_W-1:0] node, logic signed [WGT_W-1:0] w,
                         bit fixed, logic [NODE_W-1:0] e_node,
                         logic signed [WGT_W-1:0] e_wgt, logic [CNT_W-1:0] e_cnt,
                         logic e_err);
    stim_row_t row;
    row.op        = op;
    row.node      = node;
    row.wgt       = w;
    row.fixed_res = fixed;
    row.res       = '{node: e_node, wgt: e_wgt, cnt: e_cnt, err: e_err};
    dir_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: reset, directed table, then random segments
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    seg_kind_t kind;
    int        seg;
    int        seg_len;
    logic      op;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_PUSH;
    in_node_id    = '0;
    in_new_weight = '0;
    heap_cnt      = 0;
    sent_rand     = 0;
    burst_left    = 8;
    foreach (slot_of[i]) slot_of[i] = '0;
    foreach (heap_nd[i]) begin
      heap_nd[i] = '0;
      heap_wt[i] = '0;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: fixed results where they are obvious, predictor elsewhere.
    add_row(OP_POP,  7'd0,   32'sd0,   1, 7'd0,   32'sd0,   8'd0, 1'b1);  // pop on empty
    add_row(OP_PUSH, 7'd0,   WGT_MAX,  1, 7'd0,   WGT_MAX,  8'd1, 1'b0);
    add_row(OP_PUSH, 7'd127, WGT_MIN,  1, 7'd127, WGT_MIN,  8'd2, 1'b0);
    add_row(OP_PUSH, 7'd64,  32'sd0,   1, 7'd64,  32'sd0,   8'd3, 1'b0);
    add_row(OP_POP,  7'd0,   32'sd0,   1, 7'd0,   WGT_MAX,  8'd2, 1'b0);
    add_row(OP_PUSH, 7'd127, WGT_MAX,  1, 7'd127, WGT_MAX,  8'd2, 1'b0);  // raise to root
    add_row(OP_PUSH, 7'd127, -32'sd5,  1, 7'd127, -32'sd5,  8'd2, 1'b0);  // lower, stays at root
    add_row(OP_POP,  7'd0,   32'sd0,   1, 7'd127, -32'sd5,  8'd1, 1'b0);
    add_row(OP_POP,  7'd0,   32'sd0,   1, 7'd64,  32'sd0,   8'd0, 1'b0);
    add_row(OP_POP,  7'd99,  32'sd1234, 1, 7'd0,  32'sd0,   8'd0, 1'b1);  // pop ignores payload
    // equal weights: strict compares decide the order
    add_row(OP_PUSH, 7'd10,  32'sd5,   0, '0, '0, '0, 1'b0);
    add_row(OP_PUSH, 7'd11,  32'sd5,   0, '0, '0, '0, 1'b0);
    add_row(OP_PUSH, 7'd12,  32'sd5,   0, '0, '0, '0, 1'b0);
    add_row(OP_PUSH, 7'd13,  32'sd7,   0, '0, '0, '0, 1'b0);
    add_row(OP_POP,  7'd0,   32'sd0,   0, '0, '0, '0, 1'b0);
    add_row(OP_POP,  7'd0,   32'sd0,   0, '0, '0, '0, 1'b0);
    add_row(OP_POP,  7'd0,   32'sd0,   0, '0, '0, '0, 1'b0);
    add_row(OP_POP,  7'd0,   32'sd0,   0, '0, '0, '0, 1'b0);
    add_row(OP_PUSH, 7'd127, -32'sd1,  0, '0, '0, '0, 1'b0);
    add_row(OP_PUSH, 7'd0,   -32'sd1,  0, '0, '0, '0, 1'b0);
    add_row(OP_PUSH, 7'd1,   WGT_MIN,  0, '0, '0, '0, 1'b0);
    add_row(OP_PUSH, 7'd1,   -32'sd1,  0, '0, '0, '0, 1'b0);  // raise onto a tie
    add_row(OP_POP,  7'd0,   32'sd0,   0, '0, '0, '0, 1'b0);
    add_row(OP_POP,  7'd0,   32'sd0,   0, '0, '0, '0, 1'b0);
    add_row(OP_POP,  7'd0,   32'sd0,   0, '0, '0, '0, 1'b0);

    foreach (dir_rows[i])
      offer(dir_rows[i].op, dir_rows[i].node, dir_rows[i].wgt,
            dir_rows[i].fixed_res, dir_rows[i].res);
    drain_wait();

    // Random part: fill to capacity, churn, drain past empty, tie-heavy churn.
    seg = 0;
    while (sent_rand < RANDOM_ITEMS) begin
      kind = seg_kind_t'(seg % 4);
      case (kind)
        SEG_FILL: begin
          while (heap_cnt < HEAP_DEPTH) begin
            seg_len = $urandom_range(0, 19);
            if (seg_len < 17)      issue(OP_PUSH, PICK_ABSENT, rand_style());
            else if (seg_len < 19) issue(OP_PUSH, PICK_PRESENT, rand_style());
            else                   issue(OP_POP, PICK_ANY, rand_style());
          end
          // raises while full, then a quiet point
          repeat (30) issue(OP_PUSH, PICK_ANY, rand_style());
          drain_wait();
        end
        SEG_DRAIN: begin
          while (heap_cnt > 0) begin
            op = ($urandom_range(0, 99) < 85) ? OP_POP : OP_PUSH;
            issue(op, PICK_ANY, rand_style());
          end
          repeat (3) issue(OP_POP, PICK_ANY, W_FULL);
        end
        SEG_TIES: begin
          seg_len = $urandom_range(40, 120);
          repeat (seg_len) begin
            op = ($urandom_range(0, 99) < 60) ? OP_PUSH : OP_POP;
            issue(op, PICK_ANY, W_TIE);
          end
        end
        default: begin
          seg_len = $urandom_range(60, 200);
          repeat (seg_len) issue(logic'($urandom_range(0, 1)), PICK_ANY, rand_style());
        end
      endcase
      seg++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_ready follows a changing pattern, with one long hold-off so
  // that the output register and the sequencer both fill and in_ready drops.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    bit       hold_done;
    logic     rdy;
    out_ready = 1'b0;
    mode      = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && got_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        RX_ALWAYS: rdy = 1'b1;
        RX_HALF:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
        default:   rdy = (mode_left % 5) != 0;
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest booked one
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [WGT_W-1:0] want,
                                      logic [WGT_W-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result, expected none actual node %0h weight %0h",
                 $time, out_result_node, out_result_weight);
        fail_cnt++;
      end else begin
        got_front = pending_res.pop_front();
        check_field("result_node",   WGT_W'(got_front.node), WGT_W'(out_result_node));
        check_field("result_weight", got_front.wgt,          out_result_weight);
        check_field("entry_count",   WGT_W'(got_front.cnt),  WGT_W'(out_entry_count));
        check_field("error_flag",    WGT_W'(got_front.err),  WGT_W'(out_error_flag));
        got_cnt++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
